// ----- hw/rtl/pfkw_pkg.sv -----
// ----------------------------------------------------------------------------
// pfkw_pkg
// Shared types and constants for the pixel fade block: pixel format codes,
// register indexes, field widths and the white words of each format.
// ----------------------------------------------------------------------------
`default_nettype none

package pfkw_pkg;

    localparam int PIXEL_W  = 32;
    localparam int CHAN_W   = 8;
    localparam int PROD_W   = 2 * CHAN_W;
    localparam int FMT_W    = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [FMT_W-1:0]     fmt_t;
    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [PROD_W-1:0]    prod_t;
    typedef logic [PIXEL_W-1:0]   pixel_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Pixel formats
    localparam fmt_t FMT_RGBX32 = 2'd0;
    localparam fmt_t FMT_RGB24  = 2'd1;
    localparam fmt_t FMT_RGB565 = 2'd2;
    localparam fmt_t FMT_RGB555 = 2'd3;

    // Register indexes
    localparam cfg_idx_t REG_PIXEL_FORMAT = 2'd0;
    localparam cfg_idx_t REG_BRIGHTNESS   = 2'd1;

    // Reset values
    localparam fmt_t  PIXEL_FORMAT_RST = FMT_RGBX32;
    localparam chan_t BRIGHTNESS_RST   = 8'hFF;

    // White words
    localparam pixel_t WHITE_24  = 32'h00FF_FFFF;
    localparam pixel_t WHITE_565 = 32'h0000_FFFF;
    localparam pixel_t WHITE_555 = 32'h0000_7FFF;

    // Per-item side information carried along the pipeline
    typedef struct packed {
        fmt_t  fmt;
        logic  white;
        chan_t top;
    } side_t;

endpackage : pfkw_pkg

`default_nettype wire

// ----- hw/rtl/pixel_fade_keep_white.sv -----
// ----------------------------------------------------------------------------
// pixel_fade_keep_white
// Dims a pixel word by a brightness level in one of four pixel formats,
// leaving pure white unchanged.
// ----------------------------------------------------------------------------
//  channel   signals                                  transfer when
//  input     start, busy, pixel_in                    start && !busy
//  result    done, pixel_out                          done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
//  One pixel per clock cycle, through the stages decode/unpack, three
//  8x8 channel multipliers, then pack into the output register.
//  busy stays low; the receiver cannot stall, so nothing is ever held back.
//  Reset (rst_n low) clears the valid bits and loads pixel_format = 0 and
//  brightness = 255. Configuration is sampled when a pixel enters.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_fade_keep_white
    import pfkw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire pixel_t   pixel_in,
    output logic          done,
    output pixel_t        pixel_out,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire cfg_idx_t cfg_index,
    input  wire logic [CHAN_W-1:0] cfg_data
);

    fmt_t  pixel_format_reg;
    chan_t brightness_reg;

    // stage 1: unpacked operands
    logic  s1_valid_reg;
    side_t s1_side_reg;
    chan_t s1_a_reg [3];
    chan_t s1_m_reg;

    // stage 2: products
    logic  s2_valid_reg;
    side_t s2_side_reg;
    prod_t s2_p_reg [3];

    // stage 3: output
    logic   done_reg;
    pixel_t pixel_out_reg;

    side_t  s1_side_next;
    chan_t  s1_a_next [3];
    chan_t  s1_m_next;
    pixel_t pixel_out_next;
    chan_t  q [3];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign pixel_out = pixel_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= PIXEL_FORMAT_RST;
            brightness_reg   <= BRIGHTNESS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_PIXEL_FORMAT)
                pixel_format_reg <= cfg_data[FMT_W-1:0];
            else if (cfg_index == REG_BRIGHTNESS)
                brightness_reg <= cfg_data;
        end
    end

    // Unpack: widen the 5- and 6-bit channels of the 16-bit formats to 8 bits and
    // scale the top 5 bits of the level by 8, so every lane takes the high byte of its product.
    always_comb
    begin
        s1_side_next.fmt   = pixel_format_reg;
        s1_side_next.top   = '0;
        s1_side_next.white = 1'b0;
        s1_m_next          = brightness_reg;
        s1_a_next[0]       = pixel_in[7:0];
        s1_a_next[1]       = pixel_in[15:8];
        s1_a_next[2]       = pixel_in[23:16];
        unique case (pixel_format_reg)
            FMT_RGBX32:
            begin
                s1_side_next.top   = pixel_in[31:24];
                s1_side_next.white = (pixel_in == WHITE_24);
            end
            FMT_RGB24:
            begin
                s1_side_next.white = (pixel_in[23:0] == WHITE_24[23:0]);
            end
            FMT_RGB565:
            begin
                s1_m_next          = {brightness_reg[7:3], 3'b000};
                s1_a_next[2]       = {pixel_in[15:11], 3'b000};
                s1_a_next[1]       = {pixel_in[10:5], 2'b00};
                s1_a_next[0]       = {pixel_in[4:0], 3'b000};
                s1_side_next.white = (pixel_in[15:0] == WHITE_565[15:0]);
            end
            default:
            begin
                s1_m_next          = {brightness_reg[7:3], 3'b000};
                s1_a_next[2]       = {pixel_in[14:10], 3'b000};
                s1_a_next[1]       = {pixel_in[9:5], 3'b000};
                s1_a_next[0]       = {pixel_in[4:0], 3'b000};
                s1_side_next.white = (pixel_in[14:0] == WHITE_555[14:0]);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_side_reg <= s1_side_next;
            s1_a_reg    <= s1_a_next;
            s1_m_reg    <= s1_m_next;
        end
        if (s1_valid_reg)
        begin
            s2_side_reg <= s1_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_p_reg[i] <= PROD_W'(s1_a_reg[i]) * PROD_W'(s1_m_reg);
            end
        end
        if (s2_valid_reg)
            pixel_out_reg <= pixel_out_next;
    end

    // Pack: take the high byte of each product and narrow to the channel width.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q[i] = s2_p_reg[i][PROD_W-1:CHAN_W];
        end
        unique case (s2_side_reg.fmt)
            FMT_RGBX32:
                pixel_out_next = s2_side_reg.white ? WHITE_24
                               : {s2_side_reg.top, q[2], q[1], q[0]};
            FMT_RGB24:
                pixel_out_next = s2_side_reg.white ? WHITE_24
                               : {8'h00, q[2], q[1], q[0]};
            FMT_RGB565:
                pixel_out_next = s2_side_reg.white ? WHITE_565
                               : {16'h0000, q[2][7:3], q[1][7:2], q[0][7:3]};
            default:
                pixel_out_next = s2_side_reg.white ? WHITE_555
                               : {17'h00000, q[2][7:3], q[1][7:3], q[0][7:3]};
        endcase
    end

endmodule : pixel_fade_keep_white

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench for pixel_fade_keep_white
// Drives pixel words through the fade block in every pixel format and at
// several brightness levels. A local model predicts each faded pixel, and
// every strobed result is checked against the oldest prediction in order.
// Directed white, near-white and channel-extreme pixels come first, then
// random phases with random gaps between transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import pfkw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        pixel_t px_in;
        pixel_t faded;
    } fade_rec_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    pixel_t   pixel_in;
    logic     done;
    pixel_t   pixel_out;
    logic     cfg_valid;
    logic     cfg_ready;
    cfg_idx_t cfg_index;
    chan_t    cfg_data;

    fade_rec_t pending_fades[$];
    fmt_t      cur_fmt    = PIXEL_FORMAT_RST;
    chan_t     cur_bright = BRIGHTNESS_RST;
    int        error_count = 0;
    int        random_sent = 0;
    bit        no_gaps = 1'b0;

    pixel_fade_keep_white DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel_in  (pixel_in),
        .done      (done),
        .pixel_out (pixel_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // 8-bit channel times level in 256ths
    function automatic chan_t scale_byte(input chan_t b, input chan_t lvl);
        prod_t p;
        p = b * lvl;
        return p[15:8];
    endfunction

    // widened 8-bit channel times level / 32
    function automatic chan_t fade_wide(input chan_t wide, input logic [4:0] lvl);
        logic [12:0] p;
        p = wide * lvl;
        return p[12:5];
    endfunction

    function automatic pixel_t faded_pixel(input fmt_t fmt, input chan_t bright,
                                           input pixel_t px);
        pixel_t     res;
        logic [4:0] lvl;
        chan_t      r;
        chan_t      g;
        chan_t      b;
        lvl = bright[7:3];
        case (fmt)
            FMT_RGBX32:
            begin
                if (px == WHITE_24)
                    res = px;
                else
                    res = {px[31:24], scale_byte(px[23:16], bright),
                           scale_byte(px[15:8], bright), scale_byte(px[7:0], bright)};
            end
            FMT_RGB24:
            begin
                if (px[23:0] == WHITE_24[23:0])
                    res = WHITE_24;
                else
                    res = {8'h00, scale_byte(px[23:16], bright),
                           scale_byte(px[15:8], bright), scale_byte(px[7:0], bright)};
            end
            FMT_RGB565:
            begin
                if (px[15:0] == WHITE_565[15:0])
                    res = WHITE_565;
                else
                begin
                    r = fade_wide({px[15:11], 3'b000}, lvl);
                    g = fade_wide({px[10:5], 2'b00}, lvl);
                    b = fade_wide({px[4:0], 3'b000}, lvl);
                    res = {16'h0000, r[7:3], g[7:2], b[7:3]};
                end
            end
            default:
            begin
                // top bit of a 555 word is dropped
                if (px[14:0] == WHITE_555[14:0])
                    res = WHITE_555;
                else
                begin
                    r = fade_wide({px[14:10], 3'b000}, lvl);
                    g = fade_wide({px[9:5], 3'b000}, lvl);
                    b = fade_wide({px[4:0], 3'b000}, lvl);
                    res = {17'h00000, r[7:3], g[7:3], b[7:3]};
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < 40)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        fade_rec_t rec;
        if (rst_n && done === 1'b1)
        begin
            if (pending_fades.size() == 0)
                report_error($sformatf("unexpected result %h", pixel_out));
            else
            begin
                rec = pending_fades.pop_front();
                if (pixel_out !== rec.faded)
                    report_error($sformatf("pixel_in %h: pixel_out %h, wanted %h",
                                           rec.px_in, pixel_out, rec.faded));
            end
        end
    end

    function automatic int idle_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_pixel(input pixel_t px);
        fade_rec_t rec;
        int        gap;
        start    <= 1'b1;
        pixel_in <= px;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        rec.px_in = px;
        rec.faded = faded_pixel(cur_fmt, cur_bright, px);
        pending_fades.push_back(rec);
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until every expected result is back, plus pipeline slack
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_fades.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input cfg_idx_t idx, input chan_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == REG_PIXEL_FORMAT)
            cur_fmt = data[FMT_W-1:0];
        else if (idx == REG_BRIGHTNESS)
            cur_bright = data;
    endtask

    task automatic configure(input fmt_t fmt, input chan_t bright);
        wait_drained();
        write_reg(REG_PIXEL_FORMAT, {6'b000000, fmt});
        write_reg(REG_BRIGHTNESS, bright);
        cfg_valid <= 1'b0;
    endtask

    function automatic pixel_t random_pixel(input fmt_t fmt);
        pixel_t px;
        pixel_t white;
        case (fmt)
            FMT_RGBX32: white = WHITE_24;
            FMT_RGB24:  white = {8'($urandom_range(0, 255)), WHITE_24[23:0]};
            FMT_RGB565: white = {16'($urandom_range(0, 65535)), WHITE_565[15:0]};
            default:    white = {17'($urandom), 15'h0000} | WHITE_555;
        endcase
        case ($urandom_range(0, 9))
            0:       px = white;
            1:       px = white ^ (32'h1 << $urandom_range(0, 23));
            2:       px = $urandom & 32'hFF00_0000;
            default: px = $urandom;
        endcase
        return px;
    endfunction

    // reset values: 32-bit format at full brightness
    task automatic test_reset_values();
        send_pixel(32'h00FF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'h1234_5678);
    endtask

    task automatic test_special_pixels();
        configure(FMT_RGBX32, 8'd0);
        send_pixel(32'hFFFF_FFFE);
        send_pixel(32'h00FF_FFFF);
        configure(FMT_RGB24, 8'd128);
        send_pixel(32'hAAFF_FFFF);
        send_pixel(32'h00FF_FFFE);
        send_pixel(32'hFF12_3456);
        configure(FMT_RGB565, 8'd255);
        send_pixel(32'h0000_FFFF);
        send_pixel(32'h5A5A_FFFF);
        send_pixel(32'hFFFF_FFFE);
        send_pixel(32'h0000_F800);
        send_pixel(32'h0000_07E0);
        send_pixel(32'h0000_001F);
        configure(FMT_RGB565, 8'd7);
        send_pixel(32'h0000_1234);
        send_pixel(32'hFFFF_FFFF);
        configure(FMT_RGB555, 8'd8);
        send_pixel(32'h0000_7FFF);
        send_pixel(32'h0000_FFFF);
        send_pixel(32'hFFFF_8000);
        send_pixel(32'h0000_7C00);
        send_pixel(32'h0000_03E0);
        send_pixel(32'h0000_001F);
        send_pixel(32'h0000_7FFE);
        send_pixel(32'h0000_FFFE);
    endtask

    task automatic test_random_phases();
        int    phase;
        int    count;
        fmt_t  fmt;
        chan_t bright;
        phase = 0;
        while (random_sent < 1750)
        begin
            if (phase < 8)
            begin
                fmt    = fmt_t'(phase % 4);
                bright = (phase < 4) ? 8'd0 : 8'd255;
            end
            else
            begin
                fmt = fmt_t'($urandom_range(0, 3));
                case ($urandom_range(0, 5))
                    0:       bright = 8'd0;
                    1:       bright = 8'd255;
                    2:       bright = 8'd7;
                    3:       bright = 8'd8;
                    default: bright = 8'($urandom_range(0, 255));
                endcase
            end
            configure(fmt, bright);
            no_gaps = ($urandom_range(0, 3) == 0);
            count = $urandom_range(20, 120);
            repeat (count)
            begin
                send_pixel(random_pixel(cur_fmt));
                random_sent++;
                // drain the pipe now and then with the config unchanged
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
            end
            phase++;
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int i;
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel_in  = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_PIXEL_FORMAT;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_special_pixels();
        test_random_phases();

        start <= 1'b0;
        for (i = 0; i < 200 && pending_fades.size() != 0; i++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_fades.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_fades.size()));

        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule : testbench

`default_nettype wire
